// File: hw/rtl/segment_segment_distance_top_defines.svh
`ifndef SEGMENT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`define SEGMENT_SEGMENT_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication that also holds while reset is applied.
`define SSD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ssd_pkg.sv
package ssd_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ST_BITS    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int DOT_W      = SQ_W + 3;
	localparam int MUL_W      = ((DOT_W + 6) / 4) * 4;
	localparam int N_CHUNK    = 4;
	localparam int CHUNK_W    = MUL_W / N_CHUNK;
	localparam int PROD_W     = 2 * MUL_W + 1;
	localparam int DIV_W      = 2 * DOT_W + 4;
	localparam int Q_W        = ST_BITS + 1;
	localparam int V_W        = DIFF_W + ST_BITS + 4;
	localparam int SUM_W      = 2 * V_W + 2;
	localparam int RAD_W      = SUM_W - 2 * ST_BITS;
	localparam int DIST_W     = COORD_W + 1;
	localparam int SQRT_STEPS = COORD_W + 1;

	localparam longint DEGEN_THRESH = ((64'(1) << (2 * FRAC_BITS)) + 50000) / 100000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic [Q_W-1:0]            q_t;
	typedef diff_t [2:0]               vec3_t;

	localparam dot_t THRESH = DOT_W'(DEGEN_THRESH);
	localparam q_t   ST_ONE = Q_W'(1) << ST_BITS;

	typedef struct packed {
		vec3_t d1;
		vec3_t d2;
		vec3_t r;
		dot_t  a;
		dot_t  e;
		dot_t  f;
		dot_t  c;
		dot_t  b;
		logic  pdeg;
		logic  qdeg;
		logic  to_t;
		q_t    s;
		q_t    t;
	} ctx_t;

	function automatic diff_t diff_ext(coord_t x, coord_t y);
		return DIFF_W'(x) - DIFF_W'(y);
	endfunction

endpackage

// File: hw/rtl/ssd_mul.sv
module ssd_mul import ssd_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p
);

	logic [MUL_W-1:0]     mag_a;
	logic [MUL_W-1:0]     mag_b;
	logic [2*CHUNK_W-1:0] part_s1 [N_CHUNK][N_CHUNK];
	logic                 neg_s1;
	logic [2*MUL_W-1:0]   row_c [N_CHUNK];
	logic [2*MUL_W-1:0]   row_s2 [N_CHUNK];
	logic                 neg_s2;
	logic [2*MUL_W-1:0]   mag_c;
	logic signed [PROD_W-1:0] p_s3;

	always_comb begin
		mag_a = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
		mag_b = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[MUL_W-1] ^ b[MUL_W-1];
			for (int i = 0; i < N_CHUNK; i++) begin
				for (int j = 0; j < N_CHUNK; j++) begin
					part_s1[i][j] <= mag_a[i*CHUNK_W +: CHUNK_W] * mag_b[j*CHUNK_W +: CHUNK_W];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < N_CHUNK; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < N_CHUNK; j++) begin
				row_c[i] = row_c[i] + ((2*MUL_W)'(part_s1[i][j]) << (CHUNK_W * j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_c;
			neg_s2 <= neg_s1;
		end
	end

	always_comb begin
		mag_c = '0;
		for (int i = 0; i < N_CHUNK; i++) begin
			mag_c = mag_c + (row_s2[i] << (CHUNK_W * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= neg_s2 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		end
	end

	assign p = p_s3;

endmodule

// File: hw/rtl/ssd_div.sv
module ssd_div import ssd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [DIV_W-1:0] num,
	input  logic signed [DIV_W-1:0] den,
	input  ctx_t                    in_ctx,
	output logic                    out_valid,
	output q_t                      q,
	output ctx_t                    out_ctx
);

	localparam int STEPS = ST_BITS;

	logic [DIV_W-1:0] rem_s [STEPS+1];
	logic [DIV_W-1:0] den_s [STEPS+1];
	q_t               quo_s [STEPS+1];
	logic             zero_s [STEPS+1];
	logic             one_s [STEPS+1];
	ctx_t             ctx_s [STEPS+1];
	logic             vld_s [STEPS+1];
	logic [DIV_W-1:0] sh_c [STEPS];
	logic             ge_c [STEPS];

	always_comb begin
		for (int i = 0; i < STEPS; i++) begin
			sh_c[i] = {rem_s[i][DIV_W-2:0], 1'b0};
			ge_c[i] = sh_c[i] >= den_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 0; i < STEPS; i++) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			zero_s[0] <= (den <= 0) || (num <= 0);
			one_s[0]  <= num >= den;
			ctx_s[0]  <= in_ctx;
			for (int i = 0; i < STEPS; i++) begin
				rem_s[i+1]  <= ge_c[i] ? sh_c[i] - den_s[i] : sh_c[i];
				quo_s[i+1]  <= {quo_s[i][Q_W-2:0], ge_c[i]};
				den_s[i+1]  <= den_s[i];
				zero_s[i+1] <= zero_s[i];
				one_s[i+1]  <= one_s[i];
				ctx_s[i+1]  <= ctx_s[i];
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign q         = zero_s[STEPS] ? '0 : (one_s[STEPS] ? ST_ONE : quo_s[STEPS]);
	assign out_ctx   = ctx_s[STEPS];

endmodule

// File: hw/rtl/ssd_sqrt.sv
module ssd_sqrt import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  x,
	output logic              out_valid,
	output logic [DIST_W-1:0] root
);

	localparam int STEPS = SQRT_STEPS;

	logic [RAD_W-1:0]    x_s [STEPS+1];
	logic [DIST_W-1:0]   res_s [STEPS+1];
	logic [2*DIST_W-1:0] sq_s [STEPS+1];
	logic                vld_s [STEPS+1];
	logic [RAD_W-1:0]    cand_c [STEPS];
	logic                take_c [STEPS];

	always_comb begin
		for (int i = 0; i < STEPS; i++) begin
			cand_c[i] = RAD_W'(sq_s[i]) + (RAD_W'(res_s[i]) << (STEPS - i))
				+ (RAD_W'(1) << (2 * (STEPS - 1 - i)));
			take_c[i] = cand_c[i] <= x_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 0; i < STEPS; i++) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= x;
			res_s[0] <= '0;
			sq_s[0]  <= '0;
			for (int i = 0; i < STEPS; i++) begin
				x_s[i+1]   <= x_s[i];
				res_s[i+1] <= take_c[i] ? (res_s[i] | (DIST_W'(1) << (STEPS - 1 - i))) : res_s[i];
				sq_s[i+1]  <= take_c[i] ? cand_c[i][2*DIST_W-1:0] : sq_s[i];
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign root      = res_s[STEPS];

endmodule

// File: hw/rtl/segment_segment_distance_top.sv
// Distance between the closest points of two 3D segments P and Q.
// Input channel (in_valid/in_ready): the end points of both segments,
// signed Q16.16. Output channel (out_valid/out_ready): distance, unsigned
// Q17.16. Each input item gives exactly one output item, in order.
// Throughput: one item per cycle while the output is not stalled.
// The pipeline holds the two 33-stage clamped dividers (s, then the
// recomputed s or t), the 34-stage square root and the 3-stage split
// multipliers for the wide products.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops in the same cycle; nothing is lost
// or repeated, and the waiting result holds its value.
module segment_segment_distance_top import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  coord_t            p_start_x,
	input  coord_t            p_start_y,
	input  coord_t            p_start_z,
	input  coord_t            p_end_x,
	input  coord_t            p_end_y,
	input  coord_t            p_end_z,
	input  coord_t            q_start_x,
	input  coord_t            q_start_y,
	input  coord_t            q_start_z,
	input  coord_t            q_end_x,
	input  coord_t            q_end_y,
	input  coord_t            q_end_z,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DIST_W-1:0] distance
);

	localparam int PD_W = DIFF_W + Q_W + 1;
	localparam int MLAT = 3;

	logic en;

	ctx_t ctx_c1, ctx_s1, ctx_s2, ctx_c3, ctx_s3, ctx_c4, ctx_s7, ctx_s8, ctx_s9;
	ctx_t ctx_c8, ctx_c11;
	ctx_t ctx_c10, ctx_s10, ctx_s11, ctx_s12;
	ctx_t ctx_m [MLAT];
	ctx_t ctx_n [MLAT];
	logic v_s1, v_s2, v_s3, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;
	logic v_m [MLAT];
	logic v_n [MLAT];
	logic v_w [MLAT];

	logic signed [SQ_W-1:0] paa_s2 [3];
	logic signed [SQ_W-1:0] pee_s2 [3];
	logic signed [SQ_W-1:0] pff_s2 [3];
	logic signed [SQ_W-1:0] pcc_s2 [3];
	logic signed [SQ_W-1:0] pbb_s2 [3];

	logic signed [PROD_W-1:0] p_ae, p_bb, p_bf, p_ce, p_bs;
	logic signed [PROD_W-1:0] p_sq [3];
	logic signed [DIV_W-1:0]  denom_s7, numer_s7, tn_s9, esc_c, num2_c, den2_c;
	logic signed [DIV_W-1:0]  num2_s10, den2_s10;

	logic v_d1, v_d2;
	q_t   q1, q2;
	ctx_t ctx_d1, ctx_d2;

	logic signed [PD_W-1:0] pd1_s12 [3];
	logic signed [PD_W-1:0] pd2_s12 [3];
	logic signed [V_W-1:0]  v_s13_d [3];
	logic [SUM_W-1:0]       sum_s14;

	logic              v_root;
	logic [DIST_W-1:0] root;
	logic              out_valid_q;
	logic [DIST_W-1:0] distance_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_comb begin
		ctx_c1 = '0;
		ctx_c1.d1[0] = diff_ext(p_end_x, p_start_x);
		ctx_c1.d1[1] = diff_ext(p_end_y, p_start_y);
		ctx_c1.d1[2] = diff_ext(p_end_z, p_start_z);
		ctx_c1.d2[0] = diff_ext(q_end_x, q_start_x);
		ctx_c1.d2[1] = diff_ext(q_end_y, q_start_y);
		ctx_c1.d2[2] = diff_ext(q_end_z, q_start_z);
		ctx_c1.r[0]  = diff_ext(p_start_x, q_start_x);
		ctx_c1.r[1]  = diff_ext(p_start_y, q_start_y);
		ctx_c1.r[2]  = diff_ext(p_start_z, q_start_z);
	end

	always_comb begin
		ctx_c3 = ctx_s2;
		ctx_c3.a = DOT_W'(paa_s2[0]) + DOT_W'(paa_s2[1]) + DOT_W'(paa_s2[2]);
		ctx_c3.e = DOT_W'(pee_s2[0]) + DOT_W'(pee_s2[1]) + DOT_W'(pee_s2[2]);
		ctx_c3.f = DOT_W'(pff_s2[0]) + DOT_W'(pff_s2[1]) + DOT_W'(pff_s2[2]);
		ctx_c3.c = DOT_W'(pcc_s2[0]) + DOT_W'(pcc_s2[1]) + DOT_W'(pcc_s2[2]);
		ctx_c3.b = DOT_W'(pbb_s2[0]) + DOT_W'(pbb_s2[1]) + DOT_W'(pbb_s2[2]);
	end

	always_comb begin
		ctx_c4 = ctx_s3;
		ctx_c4.pdeg = ctx_s3.a <= THRESH;
		ctx_c4.qdeg = ctx_s3.e <= THRESH;
	end

	ssd_mul u_mul_ae (.clk, .en, .a(MUL_W'(ctx_s3.a)), .b(MUL_W'(ctx_s3.e)), .p(p_ae));
	ssd_mul u_mul_bb (.clk, .en, .a(MUL_W'(ctx_s3.b)), .b(MUL_W'(ctx_s3.b)), .p(p_bb));
	ssd_mul u_mul_bf (.clk, .en, .a(MUL_W'(ctx_s3.b)), .b(MUL_W'(ctx_s3.f)), .p(p_bf));
	ssd_mul u_mul_ce (.clk, .en, .a(MUL_W'(ctx_s3.c)), .b(MUL_W'(ctx_s3.e)), .p(p_ce));

	ssd_div u_div_s (
		.clk, .arst_n, .en,
		.in_valid(v_s7), .num(numer_s7), .den(denom_s7), .in_ctx(ctx_s7),
		.out_valid(v_d1), .q(q1), .out_ctx(ctx_d1)
	);

	always_comb begin
		ctx_c8 = ctx_d1;
		ctx_c8.s = (ctx_d1.pdeg || ctx_d1.qdeg) ? '0 : q1;
	end

	ssd_mul u_mul_bs (
		.clk, .en,
		.a(MUL_W'(ctx_s8.b)), .b(MUL_W'($signed({1'b0, ctx_s8.s}))), .p(p_bs)
	);

	always_comb begin
		ctx_c10 = ctx_s9;
		esc_c   = DIV_W'(ctx_s9.e) <<< ST_BITS;
		priority if (ctx_s9.pdeg && ctx_s9.qdeg) begin
			num2_c = '0;
			den2_c = '0;
			ctx_c10.to_t = 1'b0;
			ctx_c10.t = '0;
		end else if (ctx_s9.pdeg) begin
			num2_c = DIV_W'(ctx_s9.f);
			den2_c = DIV_W'(ctx_s9.e);
			ctx_c10.to_t = 1'b1;
			ctx_c10.t = '0;
		end else if (ctx_s9.qdeg || tn_s9 < 0) begin
			num2_c = -DIV_W'(ctx_s9.c);
			den2_c = DIV_W'(ctx_s9.a);
			ctx_c10.to_t = 1'b0;
			ctx_c10.t = '0;
		end else if (tn_s9 > esc_c) begin
			num2_c = DIV_W'(ctx_s9.b) - DIV_W'(ctx_s9.c);
			den2_c = DIV_W'(ctx_s9.a);
			ctx_c10.to_t = 1'b0;
			ctx_c10.t = ST_ONE;
		end else begin
			num2_c = tn_s9;
			den2_c = esc_c;
			ctx_c10.to_t = 1'b1;
			ctx_c10.t = '0;
		end
	end

	ssd_div u_div_st (
		.clk, .arst_n, .en,
		.in_valid(v_s10), .num(num2_s10), .den(den2_s10), .in_ctx(ctx_s10),
		.out_valid(v_d2), .q(q2), .out_ctx(ctx_d2)
	);

	always_comb begin
		ctx_c11 = ctx_d2;
		ctx_c11.s = ctx_d2.to_t ? ctx_d2.s : q2;
		ctx_c11.t = ctx_d2.to_t ? q2 : ctx_d2.t;
	end

	for (genvar k = 0; k < 3; k++) begin : g_sq
		ssd_mul u_mul_sq (
			.clk, .en, .a(MUL_W'(v_s13_d[k])), .b(MUL_W'(v_s13_d[k])), .p(p_sq[k])
		);
	end

	ssd_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid(v_s14), .x(sum_s14[SUM_W-1 -: RAD_W]),
		.out_valid(v_root), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			for (int i = 0; i < MLAT; i++) begin
				v_m[i] <= 1'b0;
				v_n[i] <= 1'b0;
				v_w[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_m[0] <= v_s3;
			v_s7 <= v_m[MLAT-1];
			v_s8 <= v_d1;
			v_n[0] <= v_s8;
			v_s9 <= v_n[MLAT-1];
			v_s10 <= v_s9;
			v_s11 <= v_d2;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_w[0] <= v_s13;
			v_s14 <= v_w[MLAT-1];
			for (int i = 1; i < MLAT; i++) begin
				v_m[i] <= v_m[i-1];
				v_n[i] <= v_n[i-1];
				v_w[i] <= v_w[i-1];
			end
			out_valid_q <= v_root;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_c1;
			ctx_s2 <= ctx_s1;
			for (int k = 0; k < 3; k++) begin
				paa_s2[k] <= $signed(ctx_s1.d1[k]) * $signed(ctx_s1.d1[k]);
				pee_s2[k] <= $signed(ctx_s1.d2[k]) * $signed(ctx_s1.d2[k]);
				pff_s2[k] <= $signed(ctx_s1.d2[k]) * $signed(ctx_s1.r[k]);
				pcc_s2[k] <= $signed(ctx_s1.d1[k]) * $signed(ctx_s1.r[k]);
				pbb_s2[k] <= $signed(ctx_s1.d1[k]) * $signed(ctx_s1.d2[k]);
			end
			ctx_s3 <= ctx_c3;
			ctx_m[0] <= ctx_c4;
			for (int i = 1; i < MLAT; i++) begin
				ctx_m[i] <= ctx_m[i-1];
				ctx_n[i] <= ctx_n[i-1];
			end
			ctx_s7   <= ctx_m[MLAT-1];
			denom_s7 <= DIV_W'(p_ae - p_bb);
			numer_s7 <= DIV_W'(p_bf - p_ce);
			ctx_s8   <= ctx_c8;
			ctx_n[0] <= ctx_s8;
			ctx_s9   <= ctx_n[MLAT-1];
			tn_s9    <= DIV_W'(p_bs) + (DIV_W'(ctx_n[MLAT-1].f) <<< ST_BITS);
			ctx_s10  <= ctx_c10;
			num2_s10 <= num2_c;
			den2_s10 <= den2_c;
			ctx_s11  <= ctx_c11;
			ctx_s12 <= ctx_s11;
			for (int k = 0; k < 3; k++) begin
				pd1_s12[k] <= $signed(ctx_s11.d1[k]) * $signed({1'b0, ctx_s11.s});
				pd2_s12[k] <= $signed(ctx_s11.d2[k]) * $signed({1'b0, ctx_s11.t});
				v_s13_d[k] <= (V_W'($signed(ctx_s12.r[k])) <<< ST_BITS)
					+ V_W'(pd1_s12[k]) - V_W'(pd2_s12[k]);
			end
			sum_s14 <= SUM_W'(p_sq[0]) + SUM_W'(p_sq[1]) + SUM_W'(p_sq[2]);
			distance_q <= root;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

endmodule

// File: hw/rtl/ssd_checker.sv
`include "segment_segment_distance_top_defines.svh"

module ssd_checker import ssd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DIST_W-1:0] distance
);

	`SSD_ASSERT(a_ready_follows_output, in_valid || !in_valid, in_ready == (!out_valid || out_ready), "in_ready does not follow the output stall")
	`SSD_ASSERT_NEXT(a_stalled_item_holds, out_valid && !out_ready, out_valid && $stable(distance), "stalled output item changed or dropped")
	`SSD_ASSERT_ALWAYS(a_reset_clears_output, !arst_n, !out_valid, "output valid during reset")

endmodule

bind segment_segment_distance_top ssd_checker u_ssd_checker (.*);
